// ===== rtl/core/m4t_pkg.sv =====
package m4t_pkg;

    localparam int DW       = 32;
    localparam int PW       = 64;
    localparam int OUT_IW   = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [3:0] {
        REQ_WR_A   = 4'd0,
        REQ_WR_B   = 4'd1,
        REQ_XFORM  = 4'd2,
        REQ_MUL_AB = 4'd3,
        REQ_MUL_BA = 4'd4,
        REQ_ADD    = 4'd5,
        REQ_SUB    = 4'd6,
        REQ_IDENT  = 4'd7,
        REQ_ZERO   = 4'd8
    } t_req;

    typedef enum logic [1:0] {
        K_MUL,
        K_ADD,
        K_SUB
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic                   vld;
        logic                   first;
        logic                   lastk;
        logic                   last;
        t_kind                  kind;
        logic                   sel_vec;
        logic                   a_dflt;
        logic                   a_one;
        logic                   b_dflt;
        logic                   b_one;
        logic [OUT_IW-1:0]      row;
        logic [OUT_IW-1:0]      col;
        logic signed [DW-1:0]   vec_val;
    } t_s1;

    typedef struct packed {
        logic [OUT_IW-1:0]      row;
        logic [OUT_IW-1:0]      col;
        logic signed [DW-1:0]   value;
        logic                   last;
    } t_res;

endpackage

// ===== rtl/core/m4t_ram.sv =====
module m4t_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/m4t_seq.sv =====
module m4t_seq
    import m4t_pkg::*;
#(
    parameter int DIM   = 4,
    localparam int NE   = DIM * DIM,
    localparam int AW   = $clog2(NE),
    localparam int IW   = $clog2(DIM)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_req_type,
    input  logic [1:0]           i_row,
    input  logic [1:0]           i_col,
    input  logic signed [DW-1:0] i_value,
    input  logic signed [DW-1:0] i_vx,
    input  logic signed [DW-1:0] i_vy,
    input  logic signed [DW-1:0] i_vz,
    input  logic signed [DW-1:0] i_vw,
    input  logic                 i_out_acc,
    output logic                 o_a_we,
    output logic                 o_b_we,
    output logic [AW-1:0]        o_waddr,
    output logic [DW-1:0]        o_wdata,
    output logic [AW-1:0]        o_a_raddr,
    output logic [AW-1:0]        o_b_raddr,
    output t_s1                  o_s1
);

    t_state                r_state, n_state;
    t_req                  r_op;
    logic [IW-1:0]         r_i, r_j, r_k;
    logic signed [DW-1:0]  r_vec [4];
    logic [NE-1:0]         r_va, r_vb;
    logic                  r_a_zero;
    logic [OQ_CW-1:0]      r_credit;
    t_s1                   r_s1;

    logic                  in_acc, wr_ok, is_mm_op;
    logic                  is_tr, is_add, k_last, j_last, i_last, issue, done;
    logic [IW-1:0]         a_r, a_c, b_r, b_c;
    logic signed [DW-1:0]  vec_k;
    t_kind                 kind;
    t_s1                   n_s1;

    assign in_acc  = i_in_valid && o_in_ready;
    assign wr_ok   = (int'(i_row) < DIM) && (int'(i_col) < DIM);
    assign o_waddr = AW'(int'(i_row) * DIM + int'(i_col));
    assign o_wdata = i_value;

    always_comb begin
        o_a_we   = 1'b0;
        o_b_we   = 1'b0;
        is_mm_op = 1'b0;
        case (t_req'(i_req_type))
            REQ_WR_A:   o_a_we = in_acc && wr_ok;
            REQ_WR_B:   o_b_we = in_acc && wr_ok;
            REQ_XFORM,
            REQ_MUL_AB,
            REQ_MUL_BA,
            REQ_ADD,
            REQ_SUB:    is_mm_op = 1'b1;
            default:    is_mm_op = 1'b0;
        endcase
    end

    assign is_tr  = (r_op == REQ_XFORM);
    assign is_add = (r_op == REQ_ADD) || (r_op == REQ_SUB);
    assign k_last = is_add || (r_k == IW'(DIM - 1));
    assign j_last = is_tr || (r_j == IW'(DIM - 1));
    assign i_last = (r_i == IW'(DIM - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && is_mm_op) n_state = S_RUN;
            S_RUN:   if (done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        issue      = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_RUN:   issue = !k_last || (r_credit < OQ_CW'(OQ_DEPTH));
            default: o_in_ready = 1'b0;
        endcase
    end

    assign done = issue && k_last && j_last && i_last;

    always_comb begin
        a_r  = r_i;
        a_c  = r_k;
        b_r  = r_k;
        b_c  = r_j;
        kind = K_MUL;
        case (r_op)
            REQ_MUL_BA: begin
                a_r = r_k;
                a_c = r_j;
                b_r = r_i;
                b_c = r_k;
            end
            REQ_ADD, REQ_SUB: begin
                a_c  = r_j;
                b_r  = r_i;
                kind = (r_op == REQ_ADD) ? K_ADD : K_SUB;
            end
            default: kind = K_MUL;
        endcase
    end

    assign o_a_raddr = AW'(int'(a_r) * DIM + int'(a_c));
    assign o_b_raddr = AW'(int'(b_r) * DIM + int'(b_c));

    always_comb begin
        vec_k = '0;
        for (int q = 0; q < 4; q++) begin
            if (int'(r_k) == q) vec_k = r_vec[q];
        end
    end

    always_comb begin
        n_s1.vld     = issue;
        n_s1.first   = (r_k == '0);
        n_s1.lastk   = k_last;
        n_s1.last    = j_last && i_last;
        n_s1.kind    = kind;
        n_s1.sel_vec = is_tr;
        n_s1.a_dflt  = !r_va[o_a_raddr];
        n_s1.a_one   = !r_a_zero && (a_r == a_c);
        n_s1.b_dflt  = !r_vb[o_b_raddr];
        n_s1.b_one   = (b_r == b_c);
        n_s1.row     = OUT_IW'(r_i);
        n_s1.col     = is_tr ? '0 : OUT_IW'(r_j);
        n_s1.vec_val = vec_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_va     <= '0;
            r_vb     <= '0;
            r_a_zero <= 1'b0;
            r_credit <= '0;
            r_s1.vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_credit <= r_credit + OQ_CW'(issue && k_last) - OQ_CW'(i_out_acc);
            r_s1     <= n_s1;
            if (o_a_we) r_va[o_waddr] <= 1'b1;
            if (o_b_we) r_vb[o_waddr] <= 1'b1;
            if (in_acc && (t_req'(i_req_type) == REQ_IDENT)) begin
                r_va     <= '0;
                r_a_zero <= 1'b0;
            end
            if (in_acc && (t_req'(i_req_type) == REQ_ZERO)) begin
                r_va     <= '0;
                r_a_zero <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_mm_op) begin
            r_op     <= t_req'(i_req_type);
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_vec[0] <= i_vx;
            r_vec[1] <= i_vy;
            r_vec[2] <= i_vz;
            r_vec[3] <= i_vw;
        end else if (issue) begin
            if (!k_last) begin
                r_k <= r_k + IW'(1);
            end else begin
                r_k <= '0;
                if (!j_last) begin
                    r_j <= r_j + IW'(1);
                end else begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== rtl/core/m4t_mac.sv =====
module m4t_mac
    import m4t_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_s1           i_s1,
    input  logic [DW-1:0] i_a_rdata,
    input  logic [DW-1:0] i_b_rdata,
    output logic          o_wr,
    output t_res          o_res
);

    localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;
    localparam logic signed [PW-1:0] SMAX = PW'(64'sd2147483647);
    localparam logic signed [PW-1:0] SMIN = -PW'(64'sd2147483648);

    logic signed [DW-1:0] a_val, b_val, op2;
    logic signed [PW-1:0] n_p, r_p, term, n_acc, r_acc;
    logic                 r_vld, r_first, r_lastk, r_last, r_done;
    t_kind                r_kind;
    logic [OUT_IW-1:0]    r_row, r_col, r_orow, r_ocol;
    logic                 r_olast;

    always_comb begin
        a_val = i_s1.a_dflt ? (i_s1.a_one ? ONE : '0) : i_a_rdata;
        b_val = i_s1.b_dflt ? (i_s1.b_one ? ONE : '0) : i_b_rdata;
        op2   = i_s1.sel_vec ? i_s1.vec_val : b_val;
        case (i_s1.kind)
            K_MUL:   n_p = PW'(a_val) * PW'(op2);
            K_ADD:   n_p = PW'(a_val) + PW'(b_val);
            K_SUB:   n_p = PW'(a_val) - PW'(b_val);
            default: n_p = '0;
        endcase
    end

    assign term  = (r_kind == K_MUL) ? (r_p >>> FRAC_BITS) : r_p;
    assign n_acc = (r_first ? '0 : r_acc) + term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= i_s1.vld;
            r_done <= r_vld && r_lastk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_first <= i_s1.first;
        r_lastk <= i_s1.lastk;
        r_last  <= i_s1.last;
        r_kind  <= i_s1.kind;
        r_row   <= i_s1.row;
        r_col   <= i_s1.col;
        if (r_vld) begin
            r_acc   <= n_acc;
            r_orow  <= r_row;
            r_ocol  <= r_col;
            r_olast <= r_last;
        end
    end

    always_comb begin
        o_res.row  = r_orow;
        o_res.col  = r_ocol;
        o_res.last = r_olast;
        if (r_acc > SMAX) begin
            o_res.value = SMAX[DW-1:0];
        end else if (r_acc < SMIN) begin
            o_res.value = SMIN[DW-1:0];
        end else begin
            o_res.value = r_acc[DW-1:0];
        end
    end

    assign o_wr = r_done;

endmodule

// ===== rtl/core/m4t_outq.sv =====
module m4t_outq
    import m4t_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_res,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    t_res             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wptr, r_rptr;
    logic [OQ_CW-1:0] r_cnt;
    logic             rd;

    assign o_valid = (r_cnt != '0);
    assign rd      = o_valid && i_ready;
    assign o_res   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) r_wptr <= OQ_AW'((int'(r_wptr) + 1) % OQ_DEPTH);
            if (rd)   r_rptr <= OQ_AW'((int'(r_rptr) + 1) % OQ_DEPTH);
            r_cnt <= r_cnt + OQ_CW'(i_wr) - OQ_CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wptr] <= i_res;
    end

endmodule

// ===== rtl/core/matrix4_transform_unit.sv =====
// Fixed-point matrix unit holding two DIM x DIM Q16.16 matrices A and B.
// Input channel (i_in_valid / o_in_ready) takes one request per beat:
// element writes, A := identity, A := zero, a vector transform by A, or
// A*B, B*A, A+B, A-B. Results leave on the output channel (o_out_valid /
// i_out_ready), one element per beat, row-major, o_last on the final one.
// Writes, identity, zero and unknown codes give no beat.
// Both matrices live in single-port-write RAMs read once per cycle; the
// multiply-accumulate consumes one element pair per cycle while the
// sequencer is not held by the result queue. A transform issues DIM*DIM
// reads, a product DIM*DIM*DIM and an add or subtract DIM*DIM. The first read
// issues the cycle after the request is taken; each element then passes the
// RAM read register, product register, accumulator and result queue. A new
// request is taken once the previous one has issued all its reads.
// A four-entry result queue decouples the receiver: when it stalls, the
// read sequencer pauses before the last read of an element while four
// results are in flight or queued, until room frees, with no result lost.
// Reset (synchronous, active low) returns A and B to identity at once via
// per-entry valid flags and empties the pipeline and queue.
module matrix4_transform_unit
    import m4t_pkg::*;
#(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [3:0]           i_req_type,
    input  logic [1:0]           i_row,
    input  logic [1:0]           i_col,
    input  logic signed [31:0]   i_value,
    input  logic signed [31:0]   i_vx,
    input  logic signed [31:0]   i_vy,
    input  logic signed [31:0]   i_vz,
    input  logic signed [31:0]   i_vw,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_out_row,
    output logic [1:0]           o_out_col,
    output logic signed [31:0]   o_out_value,
    output logic                 o_last
);

    localparam int NE = DIM * DIM;
    localparam int AW = $clog2(NE);

    logic          a_we, b_we;
    logic [AW-1:0] waddr, a_raddr, b_raddr;
    logic [DW-1:0] wdata, a_rdata, b_rdata;
    t_s1           s1;
    logic          res_wr;
    t_res          res, q_res;

    m4t_seq #(.DIM(DIM)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_value    (i_value),
        .i_vx       (i_vx),
        .i_vy       (i_vy),
        .i_vz       (i_vz),
        .i_vw       (i_vw),
        .i_out_acc  (o_out_valid && i_out_ready),
        .o_a_we     (a_we),
        .o_b_we     (b_we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_a_raddr  (a_raddr),
        .o_b_raddr  (b_raddr),
        .o_s1       (s1)
    );

    m4t_ram #(.WIDTH(DW), .DEPTH(NE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    m4t_ram #(.WIDTH(DW), .DEPTH(NE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    m4t_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_a_rdata (a_rdata),
        .i_b_rdata (b_rdata),
        .o_wr      (res_wr),
        .o_res     (res)
    );

    m4t_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_res   (res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (q_res)
    );

    assign o_out_row   = q_res.row;
    assign o_out_col   = q_res.col;
    assign o_out_value = q_res.value;
    assign o_last      = q_res.last;

endmodule

// ===== rtl/core/m4t_checker.sv =====
module m4t_checker
    import m4t_pkg::*;
#(
    parameter int DIM = 4
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [3:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_out_row,
    input logic [31:0] o_out_value,
    input logic        o_last
);

    logic in_acc, run_req;

    assign in_acc  = i_in_valid && o_in_ready;
    assign run_req = (i_req_type == REQ_XFORM) || (i_req_type == REQ_MUL_AB)
                  || (i_req_type == REQ_MUL_BA) || (i_req_type == REQ_ADD)
                  || (i_req_type == REQ_SUB);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && run_req |=> !o_in_ready)
        else $error("ready after accepting a result-producing request");

    a_quick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !run_req |=> o_in_ready)
        else $error("not ready after a one-cycle request");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_row == 2'(DIM - 1))
        else $error("last beat not on final row");

endmodule

bind matrix4_transform_unit m4t_checker #(.DIM(DIM)) u_m4t_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_req_type  (i_req_type),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_row   (o_out_row),
    .o_out_value (o_out_value),
    .o_last      (o_last)
);

// ===== sim/tb_matrix4_transform_unit.sv =====
`timescale 1ns / 1ps

module tb_matrix4_transform_unit
    import m4t_pkg::*;
();

    localparam int QMAX      = 32'h7fffffff;
    localparam int QMIN      = 32'h80000000;
    localparam int QONE      = 32'h00010000;
    localparam int N_RANDOM  = 200;
    localparam int TAIL_WAIT = 100;
    localparam int LIMIT     = 300000;

    class matrix_mirror;
        int   mat_a[16];
        int   mat_b[16];
        t_res exp_elems[$];
        int   errors;

        function new();
            load_identity(mat_a);
            load_identity(mat_b);
            errors = 0;
        endfunction

        function void load_identity(ref int m[16]);
            for (int i = 0; i < 16; i++) m[i] = (i / 4 == i % 4) ? QONE : 0;
        endfunction

        function longint qmul(int x, int y);
            longint p;
            p = longint'(x) * longint'(y);
            return p >>> 16;
        endfunction

        function int sat32(longint acc);
            if (acc > longint'(QMAX)) return QMAX;
            if (acc < longint'(QMIN)) return QMIN;
            return int'(acc);
        endfunction

        function void push_elem(int r, int c, longint acc, bit fin);
            t_res e;
            e.row   = 2'(r);
            e.col   = 2'(c);
            e.value = sat32(acc);
            e.last  = fin;
            exp_elems.push_back(e);
        endfunction

        function void take_request(logic [3:0] code, logic [1:0] r, logic [1:0] c, int v,
                                   int x, int y, int z, int w);
            int     vec[4];
            longint acc;
            vec = '{x, y, z, w};
            case (code)
                REQ_WR_A: mat_a[r * 4 + c] = v;
                REQ_WR_B: mat_b[r * 4 + c] = v;
                REQ_IDENT: load_identity(mat_a);
                REQ_ZERO: begin
                    for (int i = 0; i < 16; i++) mat_a[i] = 0;
                end
                REQ_XFORM: begin
                    for (int i = 0; i < 4; i++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++) acc += qmul(mat_a[i * 4 + k], vec[k]);
                        push_elem(i, 0, acc, i == 3);
                    end
                end
                REQ_MUL_AB, REQ_MUL_BA, REQ_ADD, REQ_SUB: begin
                    for (int i = 0; i < 4; i++) begin
                        for (int j = 0; j < 4; j++) begin
                            acc = 0;
                            case (code)
                                REQ_MUL_AB: begin
                                    for (int k = 0; k < 4; k++)
                                        acc += qmul(mat_a[i * 4 + k], mat_b[k * 4 + j]);
                                end
                                REQ_MUL_BA: begin
                                    for (int k = 0; k < 4; k++)
                                        acc += qmul(mat_b[i * 4 + k], mat_a[k * 4 + j]);
                                end
                                REQ_ADD: acc = longint'(mat_a[i * 4 + j]) + mat_b[i * 4 + j];
                                default: acc = longint'(mat_a[i * 4 + j]) - mat_b[i * 4 + j];
                            endcase
                            push_elem(i, j, acc, i == 3 && j == 3);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void match_element(logic [1:0] r, logic [1:0] c, logic [31:0] v, logic fin);
            t_res e;
            if (exp_elems.size() == 0) begin
                $error("unexpected result beat: row %0d col %0d value %0d", r, c, $signed(v));
                errors++;
                return;
            end
            e = exp_elems.pop_front();
            if (r !== e.row) begin
                $error("out_row mismatch: expected %0d, got %0d", e.row, r);
                errors++;
            end
            if (c !== e.col) begin
                $error("out_col mismatch: expected %0d, got %0d", e.col, c);
                errors++;
            end
            if (v !== e.value) begin
                $error("out_value mismatch: expected %0d, got %0d", e.value, $signed(v));
                errors++;
            end
            if (fin !== e.last) begin
                $error("last mismatch: expected %0d, got %0d", e.last, fin);
                errors++;
            end
        endfunction

        function int pending();
            return exp_elems.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [3:0]         i_req_type;
    logic [1:0]         i_row;
    logic [1:0]         i_col;
    logic signed [31:0] i_value;
    logic signed [31:0] i_vx;
    logic signed [31:0] i_vy;
    logic signed [31:0] i_vz;
    logic signed [31:0] i_vw;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_out_row;
    logic [1:0]         o_out_col;
    logic signed [31:0] o_out_value;
    logic               o_last;

    matrix_mirror mirror = new();
    bit           gaps_on;
    int           cycles;

    matrix4_transform_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_vx        (i_vx),
        .i_vy        (i_vy),
        .i_vz        (i_vz),
        .i_vw        (i_vw),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_matrix4_transform_unit: FAIL");
        $finish;
    end

    // result side: check the beat taken at this edge, then pick the next ready
    initial begin
        int stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                mirror.match_element(o_out_row, o_out_col, o_out_value, o_last);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic int rand_q();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) return $urandom_range(0, 32'h000fffff) - 32'h00080000;
        if (pick < 17) return $urandom;
        case ($urandom_range(0, 4))
            0: return QMAX;
            1: return QMIN;
            2: return 0;
            3: return -1;
            default: return QONE;
        endcase
    endfunction

    task automatic send_req(logic [3:0] code, logic [1:0] r, logic [1:0] c, int v,
                            int x, int y, int z, int w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= code;
        i_row      <= r;
        i_col      <= c;
        i_value    <= v;
        i_vx       <= x;
        i_vy       <= y;
        i_vz       <= z;
        i_vw       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        mirror.take_request(code, r, c, v, x, y, z, w);
    endtask

    task automatic send_op(logic [3:0] code);
        send_req(code, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom);
    endtask

    task automatic drain();
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        int sel;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_req_type <= 4'd0;
        i_row      <= 2'd0;
        i_col      <= 2'd0;
        i_value    <= 32'd0;
        i_vx       <= 32'd0;
        i_vy       <= 32'd0;
        i_vz       <= 32'd0;
        i_vw       <= 32'd0;
        gaps_on    = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(REQ_XFORM, 2'd0, 2'd0, 0, QMAX, QMIN, 0, -1);
        send_op(REQ_MUL_AB);
        send_req(REQ_WR_A, 2'd0, 2'd0, QMAX, 0, 0, 0, 0);
        send_req(REQ_WR_A, 2'd0, 2'd1, QMAX, 0, 0, 0, 0);
        send_req(REQ_WR_A, 2'd3, 2'd3, QMIN, -1, -1, -1, -1);
        send_req(REQ_WR_B, 2'd0, 2'd0, QMAX, 0, 0, 0, 0);
        send_req(REQ_WR_B, 2'd1, 2'd0, QMAX, 0, 0, 0, 0);
        send_req(REQ_WR_B, 2'd3, 2'd3, QMAX, 0, 0, 0, 0);
        send_req(REQ_WR_B, 2'd2, 2'd1, QMIN, 0, 0, 0, 0);
        send_op(REQ_ADD);
        send_op(REQ_SUB);
        send_op(REQ_MUL_AB);
        send_op(REQ_MUL_BA);
        send_req(REQ_XFORM, 2'd0, 2'd0, 0, QMAX, QMAX, QMIN, QMIN);
        send_req(4'd9, 2'd3, 2'd3, QMAX, 0, 0, 0, 0);
        send_req(4'd15, 2'd0, 2'd0, QMIN, 0, 0, 0, 0);
        send_op(REQ_ADD);
        send_op(REQ_IDENT);
        send_req(REQ_XFORM, 2'd0, 2'd0, 0, QONE, -QONE, QMIN, QMAX);
        send_op(REQ_ZERO);
        send_op(REQ_MUL_BA);
        send_req(REQ_XFORM, 2'd0, 2'd0, 0, QMAX, QMAX, QMAX, QMAX);
        send_op(REQ_SUB);
        i_in_valid <= 1'b0;
        drain();

        n = 0;
        while (n < N_RANDOM) begin
            gaps_on = (n < 50) || (n >= 75 && n < 150);
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                send_req(REQ_WR_A, 2'($urandom), 2'($urandom), rand_q(), $urandom, $urandom,
                         $urandom, $urandom);
            end else if (sel < 55) begin
                send_req(REQ_WR_B, 2'($urandom), 2'($urandom), rand_q(), $urandom, $urandom,
                         $urandom, $urandom);
            end else if (sel < 65) begin
                send_req(REQ_XFORM, 2'($urandom), 2'($urandom), $urandom, rand_q(), rand_q(),
                         rand_q(), rand_q());
            end else if (sel < 72) begin
                send_op(REQ_MUL_AB);
            end else if (sel < 79) begin
                send_op(REQ_MUL_BA);
            end else if (sel < 85) begin
                send_op(REQ_ADD);
            end else if (sel < 91) begin
                send_op(REQ_SUB);
            end else if (sel < 95) begin
                send_op(REQ_IDENT);
            end else if (sel < 97) begin
                send_op(REQ_ZERO);
            end else begin
                send_op(4'($urandom_range(9, 15)));
                continue;
            end
            n++;
        end
        i_in_valid <= 1'b0;

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("tb_matrix4_transform_unit: PASS");
        else
            $display("tb_matrix4_transform_unit: FAIL");
        $finish;
    end

endmodule

// ===== matrix4_transform_unit.f =====
rtl/core/m4t_pkg.sv
rtl/core/m4t_ram.sv
rtl/core/m4t_seq.sv
rtl/core/m4t_mac.sv
rtl/core/m4t_outq.sv
rtl/core/matrix4_transform_unit.sv
rtl/core/m4t_checker.sv
sim/tb_matrix4_transform_unit.sv
